// File: rtl/frs_pkg.sv
// shared constants and widths for the fractional-rate frame stepper
`timescale 1ns / 1ps

package frs_pkg;

    localparam int ELAPSED_W  = 20;
    localparam int SPEED_W    = 16;
    localparam int DUR_W      = 20;
    localparam int POS_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int RANGE_W    = POS_W + 1;
    localparam int PROD_W     = ELAPSED_W + SPEED_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [ELAPSED_W-1:0] MIN_ELAPSED = ELAPSED_W'(66);
    localparam logic [POS_W-1:0]     MAX_ADVANCE = {POS_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd5;

    localparam logic [SPEED_W-1:0] SPEED_RESET    = SPEED_W'(256);
    localparam logic [DUR_W-1:0]   DURATION_RESET = DUR_W'(6554);

    // command codes
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

endpackage

// File: rtl/frs_tick_if.sv
// tick channel: command and elapsed time
`timescale 1ns / 1ps

interface frs_tick_if
    import frs_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [ELAPSED_W-1:0] elapsed;

    modport source (output valid, output command, output elapsed, input ready);
    modport sink   (input valid, input command, input elapsed, output ready);
endinterface

// File: rtl/frs_status_if.sv
// status channel: frame, pending flag and fraction after each tick
`timescale 1ns / 1ps

interface frs_status_if
    import frs_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  frame;
    logic              first_pending;
    logic [FRAC_W-1:0] fraction;

    modport source (output valid, output frame, output first_pending, output fraction,
                    input ready);
    modport sink   (input valid, input frame, input first_pending, input fraction,
                    output ready);
endinterface

// File: rtl/frs_serdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module frs_serdiv
    #(
    parameter int DVD_W = 44,
    parameter int DVS_W = 20
    )
    (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
    );

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DVD_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/fractional_rate_frame_stepper.sv
// fractional-rate frame stepper top level: sequencer, serial multiply, shared divider
`timescale 1ns / 1ps

// Steps an animation frame from elapsed-time ticks. A restart, a tick at zero speed
// or the first-cycle load goes straight to the completion step. A running tick
// multiplies elapsed by speed one bit a cycle, divides by the frame duration on the
// bit-serial divider, then applies the advance; when the frame wraps, a modulo follows
// on the same divider. One tick is in flight at a time; the next is taken while the
// previous status beat still waits at the output register. Configuration must be
// written only while idle; the block itself does not enforce this.
module fractional_rate_frame_stepper
    import frs_pkg::*;
    #(
    parameter int FRAME_BITS = 16
    )
    (
    input  logic                  clk,
    input  logic                  rst_n,
    frs_tick_if.sink              tick,
    frs_status_if.source          status,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
    );

    localparam int SUM_W = ((FRAME_BITS > POS_W) ? FRAME_BITS : POS_W) + 1;
    localparam int DIV_W = (SUM_W > PROD_W + 8) ? SUM_W : PROD_W + 8;
    localparam int ACC_W = DIV_W + 1;
    localparam int MUL_CNT_W = $clog2(SPEED_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ADV  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // configuration
    logic [POS_W-1:0]   start_reg;
    logic [POS_W-1:0]   end_reg;
    logic               loop_reg;
    logic               rev_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [DUR_W-1:0]   dur_reg;

    // stepper state
    logic [2:0]            state_reg, state_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  first_reg, first_next;
    logic [FRAC_W-1:0]     prog_reg, prog_next;
    logic [POS_W-1:0]      adv_reg, adv_next;
    logic [ELAPSED_W-1:0]  dt_reg, dt_next;
    logic [PROD_W-1:0]     mul_reg, mul_next;
    logic [MUL_CNT_W-1:0]  mcnt_reg, mcnt_next;

    // output register
    logic              ov_reg, ov_next;
    logic [POS_W-1:0]  of_reg, of_next;
    logic              ofp_reg, ofp_next;
    logic [FRAC_W-1:0] ofr_reg, ofr_next;

    // divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dvd;
    logic [DUR_W-1:0] div_dvs;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DUR_W-1:0] div_rem;

    logic               tick_acc;
    logic [ELAPSED_W:0] mul_sum;
    logic [ACC_W-1:0]   acc;
    logic [SUM_W-1:0]   cur_ext;
    logic [SUM_W-1:0]   fwd_sum;
    logic [SUM_W-1:0]   rev_lim;
    logic [SUM_W-1:0]   rev_gap;
    logic [SUM_W-1:0]   fwd_off;
    logic [RANGE_W-1:0] range;
    logic               fwd_over;
    logic               rev_under;
    logic               wrap_go;
    logic [DIV_W-1:0]   mod_dvd;
    logic [RANGE_W-1:0] fwd_wrap;
    logic               slot_free;

    assign tick.ready = (state_reg == S_IDLE);
    assign tick_acc   = tick.valid && tick.ready;
    assign slot_free  = !ov_reg || status.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            loop_reg  <= 1'b0;
            rev_reg   <= 1'b0;
            speed_reg <= SPEED_RESET;
            dur_reg   <= DURATION_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_START:    start_reg <= cfg_data[POS_W-1:0];
                CFG_END:      end_reg   <= cfg_data[POS_W-1:0];
                CFG_LOOP:     loop_reg  <= cfg_data[0];
                CFG_REVERSE:  rev_reg   <= cfg_data[0];
                CFG_SPEED:    speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_DURATION: dur_reg   <= cfg_data[DUR_W-1:0];
                default:      ;
            endcase
        end
    end

    // shift-add multiply step: low half holds the remaining speed bits
    assign mul_sum = {1'b0, mul_reg[PROD_W-1:SPEED_W]}
                   + (mul_reg[0] ? {1'b0, dt_reg} : '0);

    assign acc = ACC_W'(prog_reg) + ACC_W'(div_quo);

    // advance against the frame range
    assign range     = RANGE_W'(end_reg) - RANGE_W'(start_reg) + 1'b1;
    assign cur_ext   = SUM_W'(frame_reg);
    assign fwd_sum   = cur_ext + SUM_W'(adv_reg);
    assign fwd_over  = fwd_sum > SUM_W'(end_reg);
    assign fwd_off   = fwd_sum - SUM_W'(start_reg);
    assign rev_lim   = SUM_W'(start_reg) + SUM_W'(adv_reg);
    assign rev_under = cur_ext < rev_lim;
    assign rev_gap   = rev_lim - cur_ext - 1'b1;
    assign wrap_go   = loop_reg && (rev_reg ? rev_under : fwd_over);
    assign mod_dvd   = rev_reg ? DIV_W'(rev_gap) : DIV_W'(fwd_off);
    assign fwd_wrap  = RANGE_W'(start_reg) + div_rem[RANGE_W-1:0];

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = mod_dvd;
        div_dvs   = DUR_W'(range);
        if (state_reg == S_MUL)
        begin
            div_start = (mcnt_reg == MUL_CNT_W'(SPEED_W - 1));
            div_dvd   = DIV_W'({mul_next, 8'b0});
            div_dvs   = (dur_reg == '0) ? DUR_W'(1) : dur_reg;
        end
        else if (state_reg == S_ADV)
        begin
            div_start = wrap_go && (start_reg <= end_reg) && (adv_reg != '0);
        end
    end

    frs_serdiv
        #(
        .DVD_W (DIV_W),
        .DVS_W (DUR_W)
        )
        u_div
        (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
        );

    always_comb
    begin
        state_next = state_reg;
        frame_next = frame_reg;
        first_next = first_reg;
        prog_next  = prog_reg;
        adv_next   = adv_reg;
        dt_next    = dt_reg;
        mul_next   = mul_reg;
        mcnt_next  = mcnt_reg;
        ov_next    = ov_reg && !status.ready;
        of_next    = of_reg;
        ofp_next   = ofp_reg;
        ofr_next   = ofr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_acc)
                begin
                    state_next = S_DONE;
                    if (tick.command == CMD_RESTART)
                    begin
                        first_next = 1'b1;
                    end
                    else if (speed_reg == '0)
                    begin
                        first_next = first_reg;
                    end
                    else if (first_reg)
                    begin
                        frame_next = FRAME_BITS'(start_reg);
                        prog_next  = '0;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        dt_next    = (tick.elapsed < MIN_ELAPSED) ? MIN_ELAPSED : tick.elapsed;
                        mul_next   = PROD_W'(speed_reg);
                        mcnt_next  = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                mul_next  = {mul_sum, mul_reg[SPEED_W-1:1]};
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MUL_CNT_W'(SPEED_W - 1))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    prog_next  = acc[FRAC_W-1:0];
                    adv_next   = (|acc[ACC_W-1:FRAC_W+POS_W]) ? MAX_ADVANCE
                                                               : acc[FRAC_W+POS_W-1:FRAC_W];
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                state_next = S_DONE;
                if ((start_reg <= end_reg) && (adv_reg != '0))
                begin
                    if (wrap_go)
                    begin
                        state_next = S_MOD;
                    end
                    else if (!rev_reg)
                    begin
                        frame_next = fwd_over ? FRAME_BITS'(end_reg) : FRAME_BITS'(fwd_sum);
                    end
                    else
                    begin
                        frame_next = rev_under ? FRAME_BITS'(start_reg)
                                               : FRAME_BITS'(cur_ext - SUM_W'(adv_reg));
                    end
                end
            end
            S_MOD:
            begin
                if (div_done)
                begin
                    frame_next = rev_reg ? FRAME_BITS'(end_reg - div_rem[POS_W-1:0])
                                         : FRAME_BITS'(fwd_wrap);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    of_next    = POS_W'(frame_reg);
                    ofp_next   = first_reg;
                    ofr_next   = prog_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            frame_reg <= '0;
            first_reg <= 1'b1;
            prog_reg  <= '0;
            ov_reg    <= 1'b0;
            mcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
            first_reg <= first_next;
            prog_reg  <= prog_next;
            ov_reg    <= ov_next;
            mcnt_reg  <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adv_reg <= adv_next;
        dt_reg  <= dt_next;
        mul_reg <= mul_next;
        of_reg  <= of_next;
        ofp_reg <= ofp_next;
        ofr_reg <= ofr_next;
    end

    assign status.valid         = ov_reg;
    assign status.frame         = of_reg;
    assign status.first_pending = ofp_reg;
    assign status.fraction      = ofr_reg;

    // divider only reports back while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV || state_reg == S_MOD))
        else $error("divider finished outside a divide or modulo wait");

    // a restart beat always leaves the first-cycle flag armed
    a_restart_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_acc && tick.command == CMD_RESTART) |=> first_reg)
        else $error("restart did not arm the first-cycle load");

    // a new status beat only comes out of the completion step
    a_beat_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !$past(ov_reg && !status.ready)) |-> $past(state_reg) == S_DONE)
        else $error("status beat loaded outside completion");

endmodule
